### rtl/dsit_pkg.sv
// Package for the descending sort block with arrival-index tags.
// It holds the field widths, the register codes, the controller states and the cell types.
// Every module of the block imports it.
package dsit_pkg;

  localparam int DATA_W        = 16;
  localparam int IDX_W         = 6;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int REG_ADDR_W    = 2;
  localparam int OUT_TDATA_W   = 32;

  localparam logic signed [DATA_W-1:0] THR_LOW_RST  = 16'sd10;
  localparam logic signed [DATA_W-1:0] THR_MID_RST  = 16'sd11;
  localparam logic signed [DATA_W-1:0] THR_HIGH_RST = 16'sd20;

  localparam logic [REG_ADDR_W-1:0] REG_THR_LOW  = 2'd0;
  localparam logic [REG_ADDR_W-1:0] REG_THR_MID  = 2'd1;
  localparam logic [REG_ADDR_W-1:0] REG_THR_HIGH = 2'd2;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } cell_data_t;

  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } cell_ctrl_t;

endpackage

### rtl/dsit_cell.sv
// One cell of the sorting chain: holds a value, its arrival tag and a valid bit.
// On an insert request it keeps, takes the new value or takes its left neighbor's entry;
// on a shift it takes its right neighbor's entry. Depends on dsit_pkg.
module dsit_cell (
  input  logic                clk,
  input  logic                rst,
  input  dsit_pkg::cell_ctrl_t ctrl,
  input  logic                left_keep,
  input  dsit_pkg::cell_data_t left_data,
  input  dsit_pkg::cell_data_t right_data,
  output dsit_pkg::cell_data_t data,
  output logic                keep
);
  import dsit_pkg::*;

  cell_data_t data_next;

  // A held value that is not below the new one stays, so equal values keep arrival order.
  assign keep = data.valid && (data.value >= ctrl.value);

  always_comb begin
    data_next = data;
    if (ctrl.shift) begin
      data_next = right_data;
    end else if (ctrl.insert && !keep) begin
      if (left_keep) begin
        data_next.valid = 1'b1;
        data_next.value = ctrl.value;
        data_next.index = ctrl.index;
      end else begin
        data_next = left_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data.valid <= data_next.valid;
    end
    data.value <= data_next.value;
    data.index <= data_next.index;
  end

endmodule

### rtl/descending_sort_with_index_tags.sv
// Top level of the descending sort block: chain of insertion cells, controller and output stage.
// Depends on dsit_pkg and dsit_cell.
//
// Usage:
//   The slave stream carries one signed 16-bit value per request in s_tdata[15:0]; s_tlast
//   marks the last value of a set. Each value gets its arrival position as a tag and is
//   placed into a chain of MAX_ITEMS cells kept sorted from largest to smallest, one
//   request per cycle while the block is filling. Equal values keep arrival order.
//   When the request with s_tlast is taken, the chain drains one entry per cycle while the
//   output is not stalled, through cell 0 into an output register. The master stream gives
//   each result with its tag, three threshold flags, an overflow flag and m_tlast on the last
//   result of the run. The final request moves the controller to draining; cell 0 is then
//   loaded into the output register. No request is taken from the final request until the
//   chain is empty and the controller has returned to filling. Values beyond MAX_ITEMS are
//   dropped and flag overflow on the whole run. When m_tready is low while a result is held,
//   the output register holds and the chain stops shifting. The threshold registers are
//   written through cfg_we, cfg_addr and cfg_wdata; the user must write them only while
//   idle, which the block itself does not enforce.
//   A synchronous reset empties the chain, clears the count and the output valid, and
//   restores the thresholds to 10, 11 and 20.
module descending_sort_with_index_tags #(
  parameter int MAX_ITEMS = dsit_pkg::MAX_ITEMS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata fields from bit 0: sample_value[15:0].
  input  logic [dsit_pkg::DATA_W-1:0]           s_tdata,
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata fields from bit 0: sorted_value[15:0], original_index[21:16], below_low[22],
  // below_mid[23], below_high[24], overflow[25], zero fill[31:26].
  output logic [dsit_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_we,
  input  logic [dsit_pkg::REG_ADDR_W-1:0]       cfg_addr,
  input  logic [dsit_pkg::DATA_W-1:0]           cfg_wdata
);
  import dsit_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] item_count;
  logic overflow_seen;
  logic run_overflow;
  logic signed [DATA_W-1:0] thr_low, thr_mid, thr_high;

  cell_ctrl_t ctrl;
  cell_data_t cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] keeps;
  logic [MAX_ITEMS-1:0] valids;

  logic in_take, store_full, load;
  logic signed [DATA_W-1:0] out_value;
  logic [IDX_W-1:0] out_index;
  logic out_low, out_mid, out_high, out_ovf;

  assign s_tready   = (state == ST_FILL);
  assign in_take    = s_tvalid && s_tready;
  assign store_full = (item_count == CNT_W'(MAX_ITEMS));
  assign load       = (state == ST_DRAIN) && cells[0].valid && (!m_tvalid || m_tready);

  always_comb begin
    ctrl.insert = in_take && !store_full;
    ctrl.shift  = load;
    ctrl.value  = s_tdata;
    ctrl.index  = IDX_W'(item_count);
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_data_t left_d, right_d;
    logic left_k;
    if (i == 0) begin : g_first
      assign left_k = 1'b1;
      assign left_d = '0;
    end else begin : g_mid
      assign left_k = keeps[i-1];
      assign left_d = cells[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cells[i+1];
    end
    dsit_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_keep  (left_k),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cells[i]),
      .keep       (keeps[i])
    );
    assign valids[i] = cells[i].valid;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (in_take && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cells[0].valid) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      item_count    <= '0;
      overflow_seen <= 1'b0;
      run_overflow  <= 1'b0;
      thr_low       <= THR_LOW_RST;
      thr_mid       <= THR_MID_RST;
      thr_high      <= THR_HIGH_RST;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        if (s_tlast) begin
          item_count    <= '0;
          overflow_seen <= 1'b0;
          run_overflow  <= overflow_seen || store_full;
        end else if (store_full) begin
          overflow_seen <= 1'b1;
        end else begin
          item_count <= item_count + 1'b1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_THR_LOW:  thr_low  <= cfg_wdata;
          REG_THR_MID:  thr_mid  <= cfg_wdata;
          REG_THR_HIGH: thr_high <= cfg_wdata;
          default: ;
        endcase
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= cells[0].value;
      out_index <= cells[0].index;
      out_low   <= cells[0].value < thr_low;
      out_mid   <= cells[0].value < thr_mid;
      out_high  <= cells[0].value < thr_high;
      out_ovf   <= run_overflow;
      m_tlast   <= (MAX_ITEMS > 1) ? !cells[1 % MAX_ITEMS].valid : 1'b1;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - DATA_W - IDX_W - 4){1'b0}},
                    out_ovf, out_high, out_mid, out_low, out_index, out_value};

  // While filling, the occupied cells match the number of values held.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> $countones(valids) == int'(item_count))
    else $error("chain occupancy differs from item count");

  // A final request starts a drain with a fresh count.
  a_final_starts_drain: assert property (@(posedge clk) disable iff (rst)
    in_take && s_tlast |=> state == ST_DRAIN && item_count == '0 && !overflow_seen)
    else $error("final request did not start a drain");

  // Results are only loaded while draining.
  a_load_in_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |=> !($rose(m_tvalid) && $past(state) == ST_FILL))
    else $error("result produced while filling");

endmodule

### dv/descending_sort_with_index_tags_test.sv
`timescale 1ns / 1ps
// Self-checking test for descending_sort_with_index_tags: sets of signed values are streamed in,
// and every sorted result is checked against an insertion-sort predictor with tie ordering.
// Depends on dsit_pkg and the descending_sort_with_index_tags RTL.
module descending_sort_with_index_tags_test;
  import dsit_pkg::*;

  localparam int SET_CAP = MAX_ITEMS_DEF;
  localparam int HOLD_LEN = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP = 40;
  localparam logic [REG_ADDR_W-1:0] REG_NONE = 2'd3;

  localparam int VAL_ANY = 0;
  localparam int VAL_NEAR = 1;
  localparam int VAL_EDGE = 2;
  localparam int VAL_FEW = 3;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sample_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     below_low;
    logic                     below_mid;
    logic                     below_high;
    logic                     overflow;
    logic                     run_end;
  } sorted_entry_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [REG_ADDR_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  sample_t pending_samples[$];
  sorted_entry_t expected_sorted[$];
  sample_t next_sample;
  sorted_entry_t want;

  logic signed [DATA_W-1:0] chain_value[SET_CAP];
  logic [IDX_W-1:0] chain_index[SET_CAP];
  int chain_count = 0;
  logic chain_dropped = 1'b0;
  logic signed [DATA_W-1:0] thr_low = THR_LOW_RST;
  logic signed [DATA_W-1:0] thr_mid = THR_MID_RST;
  logic signed [DATA_W-1:0] thr_high = THR_HIGH_RST;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_kick = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  descending_sort_with_index_tags dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, exp_val);
    end
    mismatches++;
  endtask

  task automatic sort_sample(input logic signed [DATA_W-1:0] v, input logic fin);
    int pos;
    sorted_entry_t e;
    if (chain_count < SET_CAP) begin
      pos = chain_count;
      while (pos > 0 && chain_value[pos-1] < v) begin
        chain_value[pos] = chain_value[pos-1];
        chain_index[pos] = chain_index[pos-1];
        pos--;
      end
      chain_value[pos] = v;
      chain_index[pos] = chain_count[IDX_W-1:0];
      chain_count++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (fin) begin
      for (int k = 0; k < chain_count; k++) begin
        e.value = chain_value[k];
        e.index = chain_index[k];
        e.below_low = chain_value[k] < thr_low;
        e.below_mid = chain_value[k] < thr_mid;
        e.below_high = chain_value[k] < thr_high;
        e.overflow = chain_dropped;
        e.run_end = (k == chain_count - 1);
        expected_sorted.push_back(e);
      end
      chain_count = 0;
      chain_dropped = 1'b0;
    end
  endtask

  // Sender side.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_sample = pending_samples.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_sample.value;
        s_tlast <= next_sample.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_kick && hold_left == 0) begin
      hold_left <= HOLD_LEN;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checks results first, then feeds the predictor with the accepted request.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_sorted.size() == 0) begin
          report("unexpected result", m_tdata, '0);
        end else begin
          want = expected_sorted.pop_front();
          if (m_tdata[15:0] !== want.value)
            report("sorted_value", 32'(m_tdata[15:0]), 32'(unsigned'(want.value)));
          if (m_tdata[21:16] !== want.index)
            report("original_index", 32'(m_tdata[21:16]), 32'(want.index));
          if (m_tdata[22] !== want.below_low)
            report("below_low", 32'(m_tdata[22]), 32'(want.below_low));
          if (m_tdata[23] !== want.below_mid)
            report("below_mid", 32'(m_tdata[23]), 32'(want.below_mid));
          if (m_tdata[24] !== want.below_high)
            report("below_high", 32'(m_tdata[24]), 32'(want.below_high));
          if (m_tdata[25] !== want.overflow)
            report("overflow", 32'(m_tdata[25]), 32'(want.overflow));
          if (m_tlast !== want.run_end)
            report("run_end", 32'(m_tlast), 32'(want.run_end));
        end
      end
      if (s_tvalid && s_tready) begin
        sort_sample(s_tdata, s_tlast);
      end
    end
  end

  task automatic push_sample(input logic signed [DATA_W-1:0] v, input logic fin);
    sample_t s;
    s.value = v;
    s.last = fin;
    pending_samples.push_back(s);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input int style);
    logic signed [DATA_W-1:0] v;
    case (style)
      VAL_NEAR: begin
        v = DATA_W'($signed($urandom_range(27)) - 3);
      end
      VAL_EDGE: begin
        case ($urandom_range(3))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = 16'sh8001;
          default: v = 16'sh7ffe;
        endcase
      end
      VAL_FEW: begin
        v = DATA_W'($urandom_range(3));
      end
      default: begin
        v = DATA_W'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic push_set(input int size, input int style);
    for (int i = 0; i < size; i++) begin
      push_sample(pick_value(style), i == size - 1);
    end
  endtask

  task automatic push_sets(input int target);
    int count;
    int size;
    count = 0;
    while (count < target) begin
      size = $urandom_range(1, 10);
      push_set(size, $urandom_range(VAL_FEW));
      count += size;
    end
  endtask

  task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_THR_LOW: thr_low = data;
      REG_THR_MID: thr_mid = data;
      REG_THR_HIGH: thr_high = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_sorted.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 33;
    rx_idle_pct = 48;
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd10, 1'b0);
    push_sample(16'sd9, 1'b0);
    push_sample(16'sd11, 1'b0);
    push_sample(16'sd20, 1'b0);
    push_sample(16'sd19, 1'b0);
    push_sample(16'sd21, 1'b0);
    push_sample(16'sd5, 1'b1);
    wait_idle();

    write_reg(REG_NONE, 16'h8000);
    push_sample(16'sd10, 1'b0);
    push_sample(16'sd10, 1'b0);
    push_sample(16'sd20, 1'b1);
    wait_idle();

    write_reg(REG_THR_LOW, DATA_W'($urandom));
    write_reg(REG_THR_MID, DATA_W'($urandom));
    write_reg(REG_THR_HIGH, DATA_W'($urandom));
    push_sets(60);
    push_set(SET_CAP, $urandom_range(VAL_FEW));
    wait_idle();

    tx_idle_pct = 48;
    rx_idle_pct = 33;
    write_reg(REG_THR_LOW, 16'h8000);
    write_reg(REG_THR_MID, 16'h7fff);
    write_reg(REG_THR_HIGH, 16'h0000);
    push_set(SET_CAP + 2, $urandom_range(VAL_FEW));
    push_sets(50);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_THR_LOW, 16'h7fff);
    write_reg(REG_THR_MID, 16'h8000);
    write_reg(REG_THR_HIGH, DATA_W'($urandom));
    for (int i = 0; i < 4; i++) begin
      push_set(8, $urandom_range(VAL_FEW));
    end
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    wait_idle();

    write_reg(REG_THR_LOW, DATA_W'($urandom));
    write_reg(REG_THR_MID, DATA_W'($urandom));
    write_reg(REG_THR_HIGH, DATA_W'($urandom));
    push_sets(50);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
